### rtl/lsm_pkg.sv
package lsm_pkg;

  localparam int COORD_W     = 16;
  localparam int DIST_W      = 16;
  localparam int NUM_ANCH    = 4;
  localparam int NUM_ROWS    = NUM_ANCH - 1;
  localparam int SQ_W        = 2 * DIST_W;
  localparam int DD_W        = SQ_W + 1;
  localparam int AX_W        = COORD_W + 1;
  localparam int CSQ_W       = 2 * COORD_W;
  localparam int BB_W        = 35;
  localparam int PM_W        = 2 * AX_W;
  localparam int PG_W        = AX_W + BB_W;
  localparam int M_W         = 35;
  localparam int G_W         = 52;
  localparam int MUL_A_W     = 52;
  localparam int MUL_B_W     = 35;
  localparam int MUL_A_LO    = 26;
  localparam int MUL_B_LO    = 18;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int DIV_W       = 96;
  localparam int QUO_W       = 25;
  localparam int POS_W       = 24;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [QUO_W-1:0] POS_LIM_POS = QUO_W'(2 ** (POS_W - 1) - 1);
  localparam logic [QUO_W-1:0] POS_LIM_NEG = QUO_W'(2 ** (POS_W - 1));

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef point_t [NUM_ANCH-1:0] anchors_t;

  localparam anchors_t ANCHOR_RESET = {
    point_t'{16'sd0,   16'sd256},
    point_t'{16'sd0,   16'sd0},
    point_t'{16'sd384, 16'sd0},
    point_t'{16'sd384, 16'sd256}
  };

  typedef logic [DD_W-1:0] dd_t;
  typedef dd_t [NUM_ROWS-1:0] dd_vec_t;

  typedef struct packed {
    logic singular;
    logic neg;
  } side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    singular;
    logic                    saturated;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A1_X = 4'd0,
    REG_A1_Y = 4'd1,
    REG_A2_X = 4'd2,
    REG_A2_Y = 4'd3,
    REG_A3_X = 4'd4,
    REG_A3_Y = 4'd5,
    REG_A4_X = 4'd6,
    REG_A4_Y = 4'd7
  } cfg_reg_e;

endpackage

### rtl/lsm_mul.sv
module lsm_mul (
  input  logic                               clk_i,
  input  logic signed [lsm_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [lsm_pkg::MUL_B_W-1:0] b_i,
  output logic signed [lsm_pkg::PROD_W-1:0]  p_o
);
  import lsm_pkg::*;

  // Operands split into a signed high part and an unsigned low part.
  logic signed [MUL_A_LO:0]           a_lo;
  logic signed [MUL_A_W-MUL_A_LO-1:0] a_hi;
  logic signed [MUL_B_LO:0]           b_lo;
  logic signed [MUL_B_W-MUL_B_LO-1:0] b_hi;

  logic signed [MUL_A_LO+MUL_B_LO+1:0]           pp_ll_q;
  logic signed [MUL_A_W-MUL_A_LO+MUL_B_LO:0]     pp_hl_q;
  logic signed [MUL_A_LO+MUL_B_W-MUL_B_LO:0]     pp_lh_q;
  logic signed [MUL_A_W-MUL_A_LO+MUL_B_W-MUL_B_LO-1:0] pp_hh_q;
  logic signed [PROD_W-1:0] sum_lo_q;
  logic signed [PROD_W-1:0] sum_hi_q;

  assign a_lo = $signed({1'b0, a_i[MUL_A_LO-1:0]});
  assign a_hi = a_i[MUL_A_W-1:MUL_A_LO];
  assign b_lo = $signed({1'b0, b_i[MUL_B_LO-1:0]});
  assign b_hi = b_i[MUL_B_W-1:MUL_B_LO];

  always_ff @(posedge clk_i) begin
    pp_ll_q  <= a_lo * b_lo;
    pp_hl_q  <= a_hi * b_lo;
    pp_lh_q  <= a_lo * b_hi;
    pp_hh_q  <= a_hi * b_hi;
    sum_lo_q <= PROD_W'(pp_ll_q) + (PROD_W'(pp_hl_q) <<< MUL_A_LO);
    sum_hi_q <= PROD_W'(pp_lh_q) + (PROD_W'(pp_hh_q) <<< MUL_A_LO);
    p_o      <= sum_lo_q + (sum_hi_q <<< MUL_B_LO);
  end

endmodule

### rtl/lsm_div.sv
module lsm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [lsm_pkg::PROD_W-1:0]  mag_i,
  input  logic [lsm_pkg::PROD_W-1:0]  det_i,
  input  lsm_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [lsm_pkg::QUO_W-1:0]   quo_o,
  output lsm_pkg::side_t              side_o
);
  import lsm_pkg::*;

  // Restoring division of (mag + det) by 2*det, one quotient bit per stage.
  logic             v_q   [QUO_W+1];
  logic [DIV_W-1:0] rem_q [QUO_W+1];
  logic [DIV_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  side_t            side_q[QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= DIV_W'(mag_i) + DIV_W'(det_i);
    den_q[0]  <= DIV_W'(det_i) << 1;
    quo_q[0]  <= '0;
    side_q[0] <= side_i;
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;
    logic [DIV_W-1:0] trial;
    logic             ge;

    assign trial = den_q[s] << K;
    assign ge    = rem_q[s] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? rem_q[s] - trial : rem_q[s];
      den_q[s+1]  <= den_q[s];
      quo_q[s+1]  <= ge ? (quo_q[s] | (QUO_W'(1) << K)) : quo_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = v_q[QUO_W];
  assign quo_o   = quo_q[QUO_W];
  assign side_o  = side_q[QUO_W];

endmodule

### rtl/lsm_front.sv
module lsm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lsm_pkg::DIST_W-1:0]    dist_one_i,
  input  logic [lsm_pkg::DIST_W-1:0]    dist_two_i,
  input  logic [lsm_pkg::DIST_W-1:0]    dist_three_i,
  input  logic [lsm_pkg::DIST_W-1:0]    dist_four_i,
  input  logic                          full_i,
  output logic                          busy_o,
  output logic                          push_o,
  output lsm_pkg::dd_vec_t              dd_o
);
  import lsm_pkg::*;

  logic [SQ_W-1:0] sq1, sq2, sq3, sq4;
  logic            accept;
  logic            v_q, v_d;
  dd_vec_t         dd_q;

  assign sq1 = dist_one_i * dist_one_i;
  assign sq2 = dist_two_i * dist_two_i;
  assign sq3 = dist_three_i * dist_three_i;
  assign sq4 = dist_four_i * dist_four_i;

  assign push_o = v_q && !full_i;
  assign busy_o = v_q && full_i;
  assign accept = start_i && !busy_o;

  always_comb begin
    v_d = v_q;
    if (accept) begin
      v_d = 1'b1;
    end else if (push_o) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  // Each row only needs the difference of squared distances.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dd_q[0] <= {1'b0, sq1} - {1'b0, sq2};
      dd_q[1] <= {1'b0, sq1} - {1'b0, sq3};
      dd_q[2] <= {1'b0, sq1} - {1'b0, sq4};
    end
  end

  assign dd_o = dd_q;

endmodule

### rtl/lsm_queue.sv
module lsm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsm_pkg::dd_vec_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output lsm_pkg::dd_vec_t data_o
);
  import lsm_pkg::*;

  dd_vec_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q;
  logic [QPTR_W-1:0]  rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/lsm_back.sv
module lsm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lsm_pkg::dd_vec_t   dd_i,
  input  lsm_pkg::anchors_t  anchors_i,
  output logic               valid_o,
  output lsm_pkg::result_t   result_o
);
  import lsm_pkg::*;

  // Anchor coordinates and their squares.
  logic signed [COORD_W-1:0] cx [NUM_ANCH];
  logic signed [COORD_W-1:0] cy [NUM_ANCH];
  logic signed [CSQ_W-1:0]   sqx[NUM_ANCH];
  logic signed [CSQ_W-1:0]   sqy[NUM_ANCH];

  logic signed [AX_W-1:0] ax_q [NUM_ROWS];
  logic signed [AX_W-1:0] ay_q [NUM_ROWS];
  logic signed [BB_W-1:0] bb_q [NUM_ROWS];
  logic signed [PM_W-1:0] pxx_q[NUM_ROWS];
  logic signed [PM_W-1:0] pxy_q[NUM_ROWS];
  logic signed [PM_W-1:0] pyy_q[NUM_ROWS];
  logic signed [PG_W-1:0] pxb_q[NUM_ROWS];
  logic signed [PG_W-1:0] pyb_q[NUM_ROWS];

  logic signed [M_W-1:0] m11_q, m12_q, m22_q;
  logic signed [G_W-1:0] g1_q, g2_q;
  logic signed [MUL_A_W-1:0] m11_a, m12_a;

  logic signed [PROD_W-1:0] p_dd, p_oo, p_xa, p_xb, p_ya, p_yb;
  logic signed [PROD_W-1:0] det_q, nx_q, ny_q;

  logic [PROD_W-1:0] mag_x_q, mag_y_q, detu_q;
  side_t             side_x_q, side_y_q;

  logic              v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, vo_q;
  logic              dvx, dvy;
  logic [QUO_W-1:0]  qx, qy;
  side_t             sx, sy;

  logic [QUO_W-1:0]  lim_x, lim_y, mx, my;
  logic              sat_x, sat_y;
  result_t           res_d, res_q;

  for (genvar j = 0; j < NUM_ANCH; j++) begin : g_anch
    assign cx[j]  = anchors_i[j].x;
    assign cy[j]  = anchors_i[j].y;
    assign sqx[j] = cx[j] * cx[j];
    assign sqy[j] = cy[j] * cy[j];
  end

  // Rows of the linear system, one lane per anchor beyond the first.
  for (genvar i = 0; i < NUM_ROWS; i++) begin : g_row
    logic signed [BB_W-1:0] cst;
    logic signed [DD_W-1:0] dds;

    assign dds = $signed(dd_i[i]);
    assign cst = sqx[i+1] + sqy[i+1] - sqx[0] - sqy[0];

    always_ff @(posedge clk_i) begin
      ax_q[i]  <= AX_W'(cx[i+1]) - AX_W'(cx[0]);
      ay_q[i]  <= AX_W'(cy[i+1]) - AX_W'(cy[0]);
      bb_q[i]  <= BB_W'(dds) + cst;
      pxx_q[i] <= ax_q[i] * ax_q[i];
      pxy_q[i] <= ax_q[i] * ay_q[i];
      pyy_q[i] <= ay_q[i] * ay_q[i];
      pxb_q[i] <= ax_q[i] * bb_q[i];
      pyb_q[i] <= ay_q[i] * bb_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    m11_q <= M_W'(pxx_q[0]) + M_W'(pxx_q[1]) + M_W'(pxx_q[2]);
    m12_q <= M_W'(pxy_q[0]) + M_W'(pxy_q[1]) + M_W'(pxy_q[2]);
    m22_q <= M_W'(pyy_q[0]) + M_W'(pyy_q[1]) + M_W'(pyy_q[2]);
    g1_q  <= G_W'(pxb_q[0]) + G_W'(pxb_q[1]) + G_W'(pxb_q[2]);
    g2_q  <= G_W'(pyb_q[0]) + G_W'(pyb_q[1]) + G_W'(pyb_q[2]);
  end

  assign m11_a = MUL_A_W'(m11_q);
  assign m12_a = MUL_A_W'(m12_q);

  lsm_mul u_mul_dd (.clk_i(clk_i), .a_i(m11_a), .b_i(m22_q), .p_o(p_dd));
  lsm_mul u_mul_oo (.clk_i(clk_i), .a_i(m12_a), .b_i(m12_q), .p_o(p_oo));
  lsm_mul u_mul_xa (.clk_i(clk_i), .a_i(g1_q),  .b_i(m22_q), .p_o(p_xa));
  lsm_mul u_mul_xb (.clk_i(clk_i), .a_i(g2_q),  .b_i(m12_q), .p_o(p_xb));
  lsm_mul u_mul_ya (.clk_i(clk_i), .a_i(g2_q),  .b_i(m11_q), .p_o(p_ya));
  lsm_mul u_mul_yb (.clk_i(clk_i), .a_i(g1_q),  .b_i(m12_q), .p_o(p_yb));

  always_ff @(posedge clk_i) begin
    det_q <= p_dd - p_oo;
    nx_q  <= p_xa - p_xb;
    ny_q  <= p_ya - p_yb;
    // The Gram determinant is never negative; zero means collinear anchors.
    detu_q            <= det_q;
    side_x_q.singular <= det_q == '0;
    side_y_q.singular <= det_q == '0;
    side_x_q.neg      <= nx_q[PROD_W-1];
    side_y_q.neg      <= ny_q[PROD_W-1];
    mag_x_q           <= nx_q[PROD_W-1] ? -nx_q : nx_q;
    mag_y_q           <= ny_q[PROD_W-1] ? -ny_q : ny_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      vo_q <= dvx;
    end
  end

  lsm_div u_div_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v8_q), .mag_i(mag_x_q), .det_i(detu_q),
    .side_i(side_x_q), .valid_o(dvx), .quo_o(qx), .side_o(sx)
  );

  lsm_div u_div_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v8_q), .mag_i(mag_y_q), .det_i(detu_q),
    .side_i(side_y_q), .valid_o(dvy), .quo_o(qy), .side_o(sy)
  );

  // Clip the rounded magnitude, then restore the sign.
  always_comb begin
    lim_x = sx.neg ? POS_LIM_NEG : POS_LIM_POS;
    lim_y = sy.neg ? POS_LIM_NEG : POS_LIM_POS;
    sat_x = qx > lim_x;
    sat_y = qy > lim_y;
    mx    = sat_x ? lim_x : qx;
    my    = sat_y ? lim_y : qy;
    res_d.pos_x     = sx.neg ? -POS_W'(mx) : POS_W'(mx);
    res_d.pos_y     = sy.neg ? -POS_W'(my) : POS_W'(my);
    res_d.singular  = 1'b0;
    res_d.saturated = sat_x || sat_y;
    if (sx.singular || sy.singular) begin
      res_d.pos_x     = '0;
      res_d.pos_y     = '0;
      res_d.singular  = 1'b1;
      res_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dvx && dvy) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = vo_q;
  assign result_o = res_q;

endmodule

### rtl/least_squares_multilateration_2d_top.sv
// Two-dimensional position from four measured anchor distances, solved as a
// linear least-squares problem. Coordinates and distances are in 1/256 m.
// Input channel: an item (dist_one_i .. dist_four_i) is taken at a rising
// edge with start_i high and busy_o low. The block accepts one item every
// clock cycle; busy_o only rises if the internal queue ever fills.
// Result channel: done_o is high for exactly one cycle per item, with
// pos_x_o, pos_y_o, singular_o and saturated_o valid in that cycle. The
// receiver cannot stall the block, and results leave in input order.
// Pipeline: after the accepting edge an item passes the queue write, the row,
// product and sum stages, the split multipliers, the determinant and magnitude
// stages, the quotient pipeline (an input stage plus 25 bit stages) and the
// output register. Throughput stays at one item per cycle throughout.
// Configuration: the eight anchor coordinates are written through the
// cfg channel (cfg_ready_o is always high) and should change only while no
// item is in flight. Reset loads the default anchor layout and empties all
// pipeline stages; no result beat is produced until a new item arrives.
// Collinear anchors give zero positions with singular_o set, and positions
// outside the 24-bit range are clipped with saturated_o set.
module least_squares_multilateration_2d_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [lsm_pkg::DIST_W-1:0]          dist_one_i,
  input  logic [lsm_pkg::DIST_W-1:0]          dist_two_i,
  input  logic [lsm_pkg::DIST_W-1:0]          dist_three_i,
  input  logic [lsm_pkg::DIST_W-1:0]          dist_four_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                done_o,
  output logic signed [lsm_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [lsm_pkg::POS_W-1:0]    pos_y_o,
  output logic                                singular_o,
  output logic                                saturated_o
);
  import lsm_pkg::*;

  anchors_t anchors_q;
  logic     push, full, q_valid;
  dd_vec_t  dd_front, dd_queue;
  result_t  result;

  assign cfg_ready_o = 1'b1;

  // Anchor registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchors_q <= ANCHOR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_A1_X: anchors_q[0].x <= cfg_data_i;
        REG_A1_Y: anchors_q[0].y <= cfg_data_i;
        REG_A2_X: anchors_q[1].x <= cfg_data_i;
        REG_A2_Y: anchors_q[1].y <= cfg_data_i;
        REG_A3_X: anchors_q[2].x <= cfg_data_i;
        REG_A3_Y: anchors_q[2].y <= cfg_data_i;
        REG_A4_X: anchors_q[3].x <= cfg_data_i;
        REG_A4_Y: anchors_q[3].y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsm_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i),
    .dist_one_i(dist_one_i), .dist_two_i(dist_two_i),
    .dist_three_i(dist_three_i), .dist_four_i(dist_four_i),
    .full_i(full), .busy_o(busy_o), .push_o(push), .dd_o(dd_front)
  );

  // The back end never stalls, so the head entry is popped whenever the queue holds one.
  lsm_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .data_i(dd_front),
    .pop_i(q_valid), .full_o(full), .valid_o(q_valid), .data_o(dd_queue)
  );

  lsm_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(q_valid), .dd_i(dd_queue),
    .anchors_i(anchors_q), .valid_o(done_o), .result_o(result)
  );

  assign pos_x_o     = result.pos_x;
  assign pos_y_o     = result.pos_y;
  assign singular_o  = result.singular;
  assign saturated_o = result.saturated;

  // A singular beat carries zero positions and no clipping flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && singular_o |-> pos_x_o == '0 && pos_y_o == '0 && !saturated_o)
    else $error("singular result with nonzero payload");

  // A clipped beat has at least one coordinate at a range limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      pos_x_o == 24'h7FFFFF || pos_x_o == 24'h800000 ||
      pos_y_o == 24'h7FFFFF || pos_y_o == 24'h800000)
    else $error("saturated flag without a clipped coordinate");

  // The back end drains the queue every cycle, so the input never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("queue filled up");

endmodule
